/* hw/rtl/gradient_orientation_band_mask_macros.svh */
// Assertion macros for the gradient orientation band mask checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef GRADIENT_ORIENTATION_BAND_MASK_MACROS_SVH
`define GRADIENT_ORIENTATION_BAND_MASK_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define GOBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GOBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gobm_pkg.sv */
// Shared types, constants and the arctangent table for the orientation mask.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gobm_pkg;

    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 11;      // |grad| up to 1024
    localparam int X_W       = 37;      // 2^24 pre-scale times CORDIC gain, signed
    localparam int Z_W       = 25;      // Q16 degrees, signed
    localparam int PHI_W     = 24;      // Q16 degrees up to 180, unsigned
    localparam int DEG_W     = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PRESCALE  = 24;
    localparam int ITERS     = 23;
    localparam int LATENCY   = ITERS + 3;

    localparam logic [PHI_W-1:0] DEG45_Q16 = 24'd2949120;
    localparam logic [PHI_W-1:0] DEG90_Q16 = 24'd5898240;
    localparam logic [DEG_W-1:0] DEG_HALF  = 8'd180;

    localparam logic [DEG_W-1:0] LOWER_RESET = 8'd175;
    localparam logic [DEG_W-1:0] UPPER_RESET = 8'd180;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 4'd1;

    // How the first-quadrant angle is formed
    localparam logic [2:0] MODE_ZERO = 3'd0;   // phi = 0
    localparam logic [2:0] MODE_90   = 3'd1;   // phi = 90
    localparam logic [2:0] MODE_45   = 3'd2;   // phi = 45
    localparam logic [2:0] MODE_OCT  = 3'd3;   // phi = cordic
    localparam logic [2:0] MODE_SWAP = 3'd4;   // phi = 90 - cordic

    typedef struct packed {
        logic [2:0] mode;
        logic       gx_neg;
        logic       gy_neg;
    } gobm_ctl_t;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        gobm_ctl_t             ctl;
    } gobm_item_t;

    // atan(2^-i) in Q16 degrees, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 25'sd2949120;
            1:  v = 25'sd1740967;
            2:  v = 25'sd919879;
            3:  v = 25'sd466945;
            4:  v = 25'sd234379;
            5:  v = 25'sd117304;
            6:  v = 25'sd58666;
            7:  v = 25'sd29335;
            8:  v = 25'sd14668;
            9:  v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            18: v = 25'sd14;
            19: v = 25'sd7;
            20: v = 25'sd4;
            21: v = 25'sd2;
            22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gobm_prep.sv */
// Input stage: magnitudes, octant selection and CORDIC seed vector.
// Depends on gobm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gobm_prep
    import gobm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic signed [GRAD_W-1:0] grad_x,
    input  wire logic signed [GRAD_W-1:0] grad_y,
    output logic                          out_valid,
    output gobm_item_t                    out_item
);

    logic signed [GRAD_W:0] gx_ext;
    logic signed [GRAD_W:0] gy_ext;
    logic [MAG_W-1:0]       ax;
    logic [MAG_W-1:0]       ay;
    logic [MAG_W-1:0]       large_mag;
    logic [MAG_W-1:0]       small_mag;
    logic [2:0]             mode;
    logic                   valid_reg;
    gobm_item_t             item_reg;
    gobm_item_t             item_next;

    always_comb
    begin
        gx_ext = {grad_x[GRAD_W-1], grad_x};
        gy_ext = {grad_y[GRAD_W-1], grad_y};
        // -1024 gives 1024, which still fits the magnitude width
        ax     = grad_x[GRAD_W-1] ? MAG_W'(-gx_ext) : MAG_W'(gx_ext);
        ay     = grad_y[GRAD_W-1] ? MAG_W'(-gy_ext) : MAG_W'(gy_ext);

        if (ay < ax)
        begin
            large_mag = ax;
            small_mag = ay;
        end
        else
        begin
            large_mag = ay;
            small_mag = ax;
        end

        // zero gradient and zero vertical gradient both give phi = 0
        if (ay == '0)
            mode = MODE_ZERO;
        else if (ax == '0)
            mode = MODE_90;
        else if (ax == ay)
            mode = MODE_45;
        else if (ay < ax)
            mode = MODE_OCT;
        else
            mode = MODE_SWAP;

        item_next.x          = $signed({2'b00, large_mag, {PRESCALE{1'b0}}});
        item_next.y          = $signed({2'b00, small_mag, {PRESCALE{1'b0}}});
        item_next.z          = '0;
        item_next.ctl.mode   = mode;
        item_next.ctl.gx_neg = grad_x[GRAD_W-1];
        item_next.ctl.gy_neg = grad_y[GRAD_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* hw/rtl/gobm_cordic_stage.sv */
// One vectoring CORDIC rotation with its pipeline register.
// Depends on gobm_pkg (item type, arctangent table).
`timescale 1ns / 1ps
`default_nettype none

module gobm_cordic_stage
    import gobm_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  gobm_item_t      in_item,
    output logic            out_valid,
    output gobm_item_t      out_item
);

    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic                  y_pos;
    logic                  valid_reg;
    gobm_item_t            item_reg;
    gobm_item_t            item_next;

    always_comb
    begin
        // arithmetic shift is a floor divide
        xs    = $signed(in_item.x) >>> STAGE;
        ys    = $signed(in_item.y) >>> STAGE;
        y_pos = !in_item.y[X_W-1] && (in_item.y != '0);

        item_next.ctl = in_item.ctl;
        if (y_pos)
        begin
            item_next.x = $signed(in_item.x) + ys;
            item_next.y = $signed(in_item.y) - xs;
            item_next.z = $signed(in_item.z) + atan_q16(STAGE);
        end
        else
        begin
            item_next.x = $signed(in_item.x) - ys;
            item_next.y = $signed(in_item.y) + xs;
            item_next.z = $signed(in_item.z) - atan_q16(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* hw/rtl/gobm_post.sv */
// Quadrant rebuild, fold into 0..179 and band compare; two register stages.
// Depends on gobm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gobm_post
    import gobm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  gobm_item_t            in_item,
    input  wire logic [DEG_W-1:0] lower_bound,
    input  wire logic [DEG_W-1:0] upper_bound,
    output logic                  out_valid,
    output logic [DEG_W-1:0]      out_deg,
    output logic                  out_band
);

    logic [PHI_W-1:0] oct;
    logic [PHI_W-1:0] phi;
    logic [PHI_W-1:0] mag;
    logic             va_reg;
    logic [DEG_W-1:0] deg_reg;
    logic             neg_reg;
    logic [DEG_W-1:0] d0;
    logic [DEG_W-1:0] d_next;
    logic             vb_reg;
    logic [DEG_W-1:0] orient_reg;
    logic             band_reg;

    // stage A: clamp octant angle, rebuild magnitude, take integer degrees
    always_comb
    begin
        if (in_item.z[Z_W-1])
            oct = '0;
        else if (PHI_W'(in_item.z) > DEG45_Q16)
            oct = DEG45_Q16;
        else
            oct = PHI_W'(in_item.z);

        unique case (in_item.ctl.mode)
            MODE_ZERO: phi = '0;
            MODE_90:   phi = DEG90_Q16;
            MODE_45:   phi = DEG45_Q16;
            MODE_OCT:  phi = oct;
            MODE_SWAP: phi = DEG90_Q16 - oct;
            default:   phi = '0;
        endcase

        mag = in_item.ctl.gx_neg ? ((DEG90_Q16 << 1) - phi) : phi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            deg_reg <= mag[PHI_W-1:16];
            neg_reg <= in_item.ctl.gy_neg;
        end
    end

    // stage B: 180 folds to 0, negative angles get 180 added
    always_comb
    begin
        d0     = (deg_reg == DEG_HALF) ? '0 : deg_reg;
        d_next = (neg_reg && d0 != '0) ? (DEG_HALF - d0) : d0;
    end

    always_ff @(posedge clk)
    begin
        if (va_reg)
        begin
            orient_reg <= d_next;
            band_reg   <= (d_next >= lower_bound) && (d_next <= upper_bound);
        end
    end

    assign out_valid = vb_reg;
    assign out_deg   = orient_reg;
    assign out_band  = band_reg;

endmodule

`default_nettype wire

/* hw/rtl/gradient_orientation_band_mask.sv */
// Top level of the gradient orientation band mask: config registers and pipeline.
// Depends on gobm_pkg, gobm_prep, gobm_cordic_stage, gobm_post.
//
// Usage:
//   Input channel: a pixel's grad_x/grad_y beat is taken on each rising edge
//   with start high and busy low. busy is always low, so a new pixel may be
//   presented every cycle.
//   Result channel: done pulses for one cycle with orientation_deg (0..179)
//   and in_band. The receiver cannot stall; results simply appear.
//   Pipeline: one input stage, 23 CORDIC rotation stages and two fold/compare
//   stages lie between accept and done. Throughput: one pixel per cycle.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready always high. Index 0
//   is the lower bound, index 1 the upper bound (inclusive, degrees); other
//   indexes are ignored. Write bounds only while no pixel is in flight.
//   Reset: rst_n clears all pipeline valid bits and sets the bounds to 175
//   and 180.
`timescale 1ns / 1ps
`default_nettype none

module gradient_orientation_band_mask
    import gobm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [GRAD_W-1:0] grad_x,
    input  wire logic signed [GRAD_W-1:0] grad_y,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DEG_W-1:0]         cfg_data,
    output logic                          done,
    output logic [DEG_W-1:0]              orientation_deg,
    output logic                          in_band
);

    logic [DEG_W-1:0] lower_bound_reg;
    logic [DEG_W-1:0] upper_bound_reg;
    logic             stage_valid [ITERS+1];
    gobm_item_t       stage_item  [ITERS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= LOWER_RESET;
            upper_bound_reg <= UPPER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOWER: lower_bound_reg <= cfg_data;
                CFG_UPPER: upper_bound_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    gobm_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .out_valid (stage_valid[0]),
        .out_item  (stage_item[0])
    );

    for (genvar i = 0; i < ITERS; i++)
    begin : g_cordic
        gobm_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_item   (stage_item[i]),
            .out_valid (stage_valid[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    gobm_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[ITERS]),
        .in_item     (stage_item[ITERS]),
        .lower_bound (lower_bound_reg),
        .upper_bound (upper_bound_reg),
        .out_valid   (done),
        .out_deg     (orientation_deg),
        .out_band    (in_band)
    );

endmodule

`default_nettype wire

/* hw/rtl/gobm_checker.sv */
// Port-level checker for the orientation mask, bound to the top level.
// Depends on gobm_pkg and gradient_orientation_band_mask_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_orientation_band_mask_macros.svh"

module gobm_checker
    import gobm_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic signed [GRAD_W-1:0] grad_x,
    input wire logic signed [GRAD_W-1:0] grad_y,
    input wire logic                     cfg_valid,
    input wire logic                     cfg_ready,
    input wire logic [CFG_IDX_W-1:0]     cfg_index,
    input wire logic [DEG_W-1:0]         cfg_data,
    input wire logic                     done,
    input wire logic [DEG_W-1:0]         orientation_deg,
    input wire logic                     in_band
);

    logic unused_ok;
    logic beat;
    logic zero_grad;

    assign unused_ok = cfg_valid ^ cfg_ready ^ (|cfg_index) ^ (|cfg_data) ^ in_band;
    assign beat      = start && !busy;
    assign zero_grad = (grad_x == '0) && (grad_y == '0);

    `GOBM_ASSERT_NOW(a_orient_range, done, orientation_deg < DEG_HALF, "orientation above 179")
    `GOBM_ASSERT_NOW(a_done_has_beat, done, $past(beat, LATENCY), "result without a beat")
    `GOBM_ASSERT_NOW(a_zero_grad, done && $past(zero_grad, LATENCY), orientation_deg == '0, "zero gradient")
    `GOBM_ASSERT_NEXT(a_beat_gives_result, beat, ##(LATENCY-1) done, "beat lost in pipeline")

endmodule

bind gradient_orientation_band_mask gobm_checker u_gobm_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for gradient_orientation_band_mask: directed rows, then random pixels
// across many band settings. Needs gobm_pkg and the block's RTL; expected angles and band
// flags of untyped pixels come from a CORDIC predictor written into the bench.
`timescale 1ns / 1ps

module tb;
    import gobm_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int RAND_PIXELS      = 1850;
    localparam int FIXED_PHASES     = 10;
    localparam int PHASES           = 16;
    localparam int PIXELS_PER_PHASE = RAND_PIXELS / PHASES;
    localparam int DIRECTED_ROWS    = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [DEG_W-1:0] orient;
        logic             band;
    } angle_res_t;

    typedef struct {
        int gx;
        int gy;
        bit typed;
        int orient;
        bit band;
    } pixel_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DEG_W-1:0]         cfg_data;
    logic                     done;
    logic [DEG_W-1:0]         orientation_deg;
    logic                     in_band;

    logic [DEG_W-1:0] bound_lo;
    logic [DEG_W-1:0] bound_hi;
    angle_res_t       pending_angles[$];
    int               errors;
    int               cycles;

    // atan(2^-i), Q16 degrees
    longint atan_steps [0:ITERS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    // Rows with a typed result hold what the reset band (175..180) gives
    pixel_row_t directed_pixels [0:DIRECTED_ROWS-1] = '{
        '{0, 0, 1, 0, 0},
        '{1020, 0, 1, 0, 0},
        '{-1020, 0, 1, 0, 0},
        '{0, 1020, 1, 90, 0},
        '{0, -1020, 1, 90, 0},
        '{1020, 1020, 1, 45, 0},
        '{-1020, 1020, 1, 135, 0},
        '{1020, -1020, 1, 135, 0},
        '{-1020, -1020, 1, 45, 0},
        '{1020, -1, 1, 0, 0},
        '{-1020, 1, 1, 179, 1},
        '{-1020, -1, 1, 1, 0},
        '{-1024, -1024, 1, 45, 0},
        '{-1024, 0, 1, 0, 0},
        '{0, -1024, 1, 90, 0},
        '{1023, 1023, 1, 45, 0},
        '{1023, -1024, 0, 0, 0},
        '{-1024, 1023, 0, 0, 0},
        '{3, 4, 0, 0, 0},
        '{-5, 12, 0, 0, 0},
        '{7, -1, 0, 0, 0},
        '{1, 1020, 0, 0, 0},
        '{-1, -1020, 0, 0, 0},
        '{500, -300, 0, 0, 0},
        '{-2, 1, 0, 0, 0}
    };

    int band_lo_tab [0:FIXED_PHASES-1] = '{0, 0, 179, 255, 255, 90, 0, 45, 180, 100};
    int band_hi_tab [0:FIXED_PHASES-1] = '{255, 0, 179, 0, 255, 179, 90, 135, 255, 99};

    gradient_orientation_band_mask u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .grad_x          (grad_x),
        .grad_y          (grad_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .orientation_deg (orientation_deg),
        .in_band         (in_band)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // atan(sm/big) in Q16 degrees by vectoring, 0 <= sm < big
    function automatic longint octant_atan_q16(input longint big, input longint sm);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = big * 64'sd16777216;
        y = sm * 64'sd16777216;
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(DEG45_Q16))
            z = longint'(DEG45_Q16);
        return z;
    endfunction

    function automatic angle_res_t predict_angle(input int gx, input int gy);
        longint     ax;
        longint     ay;
        longint     phi;
        longint     mag;
        longint     d;
        bit         neg;
        angle_res_t r;
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if (ay == 0)
            phi = 0;
        else if (ax == 0)
            phi = longint'(DEG90_Q16);
        else if (ax == ay)
            phi = longint'(DEG45_Q16);
        else if (ay < ax)
            phi = octant_atan_q16(ax, ay);
        else
            phi = longint'(DEG90_Q16) - octant_atan_q16(ay, ax);
        mag = (gx >= 0) ? phi : 2 * longint'(DEG90_Q16) - phi;
        neg = (gy < 0);
        d = (mag >>> 16) % 180;
        if (neg && d != 0)
            d = 180 - d;
        r.orient = d[DEG_W-1:0];
        r.band   = (r.orient >= bound_lo) && (r.orient <= bound_hi);
        return r;
    endfunction

    function automatic int to_grad(input int raw);
        return (raw >= 1024) ? raw - 2048 : raw;
    endfunction

    task automatic pick_grads(output int gx, output int gy);
        int m;
        m = $urandom_range(0, 9);
        case (m)
            5:
            begin
                gx = to_grad($urandom_range(0, 2047));
                gy = to_grad($urandom_range(0, 2047));
            end
            6:
            begin
                // one axis zero, now and then both
                gx = $urandom_range(0, 3) == 0 ? 0 : to_grad($urandom_range(0, 2047));
                gy = 0;
                if ($urandom_range(0, 1))
                begin
                    gy = gx;
                    gx = 0;
                end
            end
            7:
            begin
                gx = $urandom_range(1, 1024);
                gy = $urandom_range(0, 1) ? -gx : gx;
                if (gx == 1024 || $urandom_range(0, 1))
                    gx = -gx;
                if (gy == 1024)
                    gy = -1024;
            end
            8:
            begin
                gx = int'($urandom_range(0, 16)) - 8;
                gy = int'($urandom_range(0, 16)) - 8;
            end
            9:
            begin
                // near an axis: tiny angles and angles just short of 180
                gx = int'($urandom_range(0, 2040)) - 1020;
                gy = int'($urandom_range(0, 6)) - 3;
                if ($urandom_range(0, 1))
                begin
                    gy = gx;
                    gx = int'($urandom_range(0, 6)) - 3;
                end
            end
            default:
            begin
                gx = int'($urandom_range(0, 2040)) - 1020;
                gy = int'($urandom_range(0, 2040)) - 1020;
            end
        endcase
    endtask

    // One beat on the pixel port; start stays high afterwards
    task automatic send_pixel(input int gx, input int gy, input bit typed,
                              input int t_orient, input bit t_band);
        angle_res_t r;
        start  <= 1'b1;
        grad_x <= gx[GRAD_W-1:0];
        grad_y <= gy[GRAD_W-1:0];
        do @(posedge clk); while (busy !== 1'b0);
        if (typed)
        begin
            r.orient = t_orient[DEG_W-1:0];
            r.band   = t_band;
        end
        else
            r = predict_angle(gx, gy);
        pending_angles.push_back(r);
    endtask

    task automatic idle_gap(input bit quiet);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_angles();
        start <= 1'b0;
        do @(posedge clk); while (pending_angles.size() != 0);
    endtask

    // Back-to-back beats on the config port, optionally led by a write to a dead index
    task automatic program_bounds(input int lo, input int hi, input bit poke_unused);
        if (poke_unused)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 8'($urandom);
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOWER;
        cfg_data  <= lo[DEG_W-1:0];
        do @(posedge clk); while (cfg_ready !== 1'b1);
        bound_lo = lo[DEG_W-1:0];
        cfg_index <= CFG_UPPER;
        cfg_data  <= hi[DEG_W-1:0];
        do @(posedge clk); while (cfg_ready !== 1'b1);
        bound_hi = hi[DEG_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Results cannot be held off: check every done beat
    always @(posedge clk)
    begin
        angle_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("unexpected result: orientation_deg %0d in_band %0d",
                       orientation_deg, in_band);
                errors++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (orientation_deg !== want.orient)
                begin
                    $error("orientation_deg: expected %0d, got %0d", want.orient,
                           orientation_deg);
                    errors++;
                end
                if (in_band !== want.band)
                begin
                    $error("in_band: expected %0d, got %0d", want.band, in_band);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int gx;
        int gy;
        int lo;
        int hi;
        bit quiet;
        errors    = 0;
        cycles    = 0;
        bound_lo  = LOWER_RESET;
        bound_hi  = UPPER_RESET;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        grad_x    <= '0;
        grad_y    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_pixels[i])
        begin
            send_pixel(directed_pixels[i].gx, directed_pixels[i].gy, directed_pixels[i].typed,
                       directed_pixels[i].orient, directed_pixels[i].band);
            idle_gap(1'b0);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_angles();
            if (p < FIXED_PHASES)
            begin
                lo = band_lo_tab[p];
                hi = band_hi_tab[p];
            end
            else
            begin
                lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 179);
                hi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(lo, 255);
            end
            program_bounds(lo, hi, p == 0);
            quiet = (p % 4 == 1);
            for (int k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                pick_grads(gx, gy);
                send_pixel(gx, gy, 1'b0, 0, 1'b0);
                // sender holds off mid-stream until the pipe is empty
                if (p == 2 && k == 60)
                    drain_angles();
                else
                    idle_gap(quiet);
            end
        end

        start <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
